/* rtl/core/utf8_stream_decoder_assert.svh */
// Assertion macros for the UTF-8 stream decoder RTL.
// No dependencies; the including module must provide i_clk and i_rst_n.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Plain condition that must hold at every clock edge outside reset.
`define U8SD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define U8SD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/u8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CP_W = 31;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef enum logic [1:0] {
        K_ASCII,
        K_CONT,
        K_LEAD,
        K_BAD
    } t_kind;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        t_kind      kind;
        logic [2:0] tails;
        logic [6:0] payload;
    } t_token;

endpackage

`default_nettype wire

/* rtl/core/u8sd_front.sv */
// Front end of the UTF-8 stream decoder: classifies each raw byte.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_front (
    input  wire logic [7:0]      i_byte,
    output u8sd_pkg::t_token     o_token
);
    import u8sd_pkg::*;

    always_comb begin
        o_token.kind    = K_BAD;
        o_token.tails   = 3'd0;
        o_token.payload = 7'd0;
        priority if (!i_byte[7]) begin
            o_token.kind    = K_ASCII;
            o_token.payload = i_byte[6:0];
        end else if (!i_byte[6]) begin
            o_token.kind    = K_CONT;
            o_token.payload = {1'b0, i_byte[5:0]};
        end else if (!i_byte[5]) begin
            o_token.kind    = K_LEAD;
            o_token.tails   = 3'd1;
            o_token.payload = {2'b0, i_byte[4:0]};
        end else if (!i_byte[4]) begin
            o_token.kind    = K_LEAD;
            o_token.tails   = 3'd2;
            o_token.payload = {3'b0, i_byte[3:0]};
        end else if (!i_byte[3]) begin
            o_token.kind    = K_LEAD;
            o_token.tails   = 3'd3;
            o_token.payload = {4'b0, i_byte[2:0]};
        end else if (!i_byte[2]) begin
            o_token.kind    = K_LEAD;
            o_token.tails   = 3'd4;
            o_token.payload = {5'b0, i_byte[1:0]};
        end else if (!i_byte[1]) begin
            o_token.kind    = K_LEAD;
            o_token.tails   = 3'd5;
            o_token.payload = {6'b0, i_byte[0]};
        end else begin
            // 0xFE and 0xFF never start a sequence.
            o_token.kind = K_BAD;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u8sd_queue.sv */
// Two-entry token queue between the decoder front and back ends.
// Depends on u8sd_pkg.
`default_nettype none

module u8sd_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire u8sd_pkg::t_token i_token,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output u8sd_pkg::t_token      o_token
);
    import u8sd_pkg::*;

    t_token     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_token = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u8sd_back.sv */
// Back end of the UTF-8 stream decoder: sequence state and result register.
// Depends on u8sd_pkg and utf8_stream_decoder_assert.svh.
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module u8sd_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_tok_avail,
    input  wire u8sd_pkg::t_token            i_token,
    output logic                             o_tok_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [u8sd_pkg::CP_W-1:0]        o_code_point,
    output logic [1:0]                       o_status
);
    import u8sd_pkg::*;

    logic [CP_W-1:0] r_partial;
    logic [CP_W-1:0] n_partial;
    logic [2:0]      r_tails;
    logic [2:0]      n_tails;
    logic            r_out_valid;
    logic [CP_W-1:0] r_out_cp;
    logic [1:0]      r_out_st;
    logic            emit;
    logic [CP_W-1:0] emit_cp;
    logic [1:0]      emit_st;
    logic [CP_W-1:0] shifted;

    // A token is taken whenever the result register is free or being emptied.
    assign o_tok_pop = i_tok_avail && (!r_out_valid || i_ready);
    assign shifted   = {r_partial[CP_W-7:0], i_token.payload[5:0]};

    always_comb begin
        n_partial = r_partial;
        n_tails   = r_tails;
        emit      = 1'b0;
        emit_cp   = '0;
        emit_st   = ST_OK;
        if (r_tails == 3'd0) begin
            unique case (i_token.kind)
                K_ASCII: begin
                    emit    = 1'b1;
                    emit_cp = {{(CP_W-7){1'b0}}, i_token.payload};
                end
                K_LEAD: begin
                    n_partial = {{(CP_W-7){1'b0}}, i_token.payload};
                    n_tails   = i_token.tails;
                end
                K_CONT, K_BAD: begin
                    emit    = 1'b1;
                    emit_st = ST_INVALID;
                end
                default: begin
                    emit    = 1'b1;
                    emit_st = ST_INVALID;
                end
            endcase
        end else if (i_token.kind == K_CONT) begin
            if (r_tails == 3'd1) begin
                emit      = 1'b1;
                emit_cp   = shifted;
                n_partial = '0;
            end else begin
                n_partial = shifted;
            end
            n_tails = r_tails - 3'd1;
        end else begin
            // Any other byte inside a sequence aborts it; a zero byte is a truncation.
            emit      = 1'b1;
            emit_st   = (i_token.kind == K_ASCII && i_token.payload == 7'd0)
                        ? ST_TRUNC : ST_INVALID;
            n_partial = '0;
            n_tails   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_tails     <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_tok_pop) begin
                r_partial <= n_partial;
                r_tails   <= n_tails;
            end
            if (o_tok_pop) begin
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop && emit) begin
            r_out_cp <= emit_cp;
            r_out_st <= emit_st;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_out_cp;
    assign o_status     = r_out_st;

    `U8SD_ASSERT(a_tails_range, r_tails <= 3'd5, "tail count beyond five")
    `U8SD_ASSERT_IMP(a_idle_clear, r_tails == 3'd0, r_partial == '0,
                     "partial value left over while idle")
    `U8SD_ASSERT_IMP(a_err_zero, r_out_valid && r_out_st != ST_OK, r_out_cp == '0,
                     "error result carries a nonzero code point")
    `U8SD_ASSERT_IMP(a_st_code, r_out_valid, r_out_st != 2'd3,
                     "undefined status code")

endmodule

`default_nettype wire

/* rtl/core/utf8_stream_decoder.sv */
// UTF-8 stream decoder (six-byte form, 31-bit code points), one byte per request.
// A byte is held in the token queue, and its result then in the result register, before the result appears.
// Throughput: 1 byte per cycle while the output is not stalled, set by the shift-and-count in the back end.
// The two-entry token queue and the result register let either side stall independently.
// Reset (synchronous, active low) empties the queue, drops any open sequence and the result.
// Depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back.
`default_nettype none

module utf8_stream_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [7:0]                  i_in_byte,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [u8sd_pkg::CP_W-1:0]        o_code_point,
    output logic [1:0]                       o_status
);
    import u8sd_pkg::*;

    t_token front_tok;
    t_token queue_tok;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    logic   q_push;

    assign o_ready = !q_full;
    assign q_push  = i_valid && !q_full;

    u8sd_front u_front (
        .i_byte  (i_in_byte),
        .o_token (front_tok)
    );

    u8sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_token (queue_tok)
    );

    u8sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_avail  (!q_empty),
        .i_token      (queue_tok),
        .o_tok_pop    (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point),
        .o_status     (o_status)
    );

endmodule

`default_nettype wire
